[rtl/usbl_pkg.sv]
// Shared types and constants of the serial bootloader.
// No dependencies; the other files, apart from usbl_if, refer to it by scoped names.
`default_nettype none

package usbl_pkg;

    localparam int ADDR_BITS = 16;
    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic [31:0] RESET_PERIOD = 32'd1250;

    localparam logic [7:0] CH_PROMPT = 8'h3F;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [3:0] FRAME_BITS = 4'd10;
    localparam logic [3:0] RX_WAIT    = 4'd0;
    localparam logic [3:0] RX_HALF    = 4'd1;
    localparam logic [3:0] RX_FIRST   = 4'd2;
    localparam logic [3:0] RX_LAST    = 4'd9;

    typedef enum logic [2:0] {
        PH_PROMPT  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CR      = 3'd3,
        PH_LF      = 3'd4,
        PH_START   = 3'd5,
        PH_HALT    = 3'd6
    } t_phase;

    typedef struct packed {
        logic        tx_line;
        logic        mem_write;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
        logic        start_program;
    } t_result;

    // 8N1 frame: start bit low, data LSB first, stop bit high
    function automatic logic [9:0] frame_of(input logic [7:0] ch);
        frame_of = {1'b1, ch, 1'b0};
    endfunction

endpackage

`default_nettype wire

[rtl/usbl_if.sv]
// Handshake channels of the serial bootloader: tick input, result output, period write.
// Depends on usbl_pkg for nothing but shares its naming.
`default_nettype none

interface usbl_in_if;
    logic valid;
    logic ready;
    logic rx_line;
    modport source (output valid, output rx_line, input ready);
    modport sink (input valid, input rx_line, output ready);
endinterface

interface usbl_out_if;
    logic        valid;
    logic        ready;
    logic        tx_line;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
    logic        start_program;
    modport source (output valid, output tx_line, output mem_write, output mem_address,
                    output mem_data, output start_program, input ready);
    modport sink (input valid, input tx_line, input mem_write, input mem_address,
                  input mem_data, input start_program, output ready);
endinterface

interface usbl_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] bit_period;
    modport source (output valid, output bit_period, input ready);
    modport sink (input valid, input bit_period, output ready);
endinterface

`default_nettype wire

[rtl/uart_serial_bootloader_unit.sv]
// Top level of the serial bootloader: sequencer plus result register.
// Depends on usbl_pkg, usbl_if, usbl_core and usbl_out_reg.
//
//   channel   dir   word                                                   accepted when
//   i_rx      in    rx_line                                                valid & ready
//   o_tx      out   tx_line, mem_write, mem_address, mem_data, start_prog  valid & ready
//   i_cfg     in    bit_period                                             valid & ready
//
// One input word is one bit-timing tick and gives one result word; while the output is not
// stalled a word is taken every cycle, its result registered and shown on the next cycle.
// Throughput is set by the single result register: it refills in the cycle it drains.
// Synchronous active-low reset restarts the prompt and sets bit_period to 1250.
// A stalled output holds the input off; the period register is always writable.
`default_nettype none

module uart_serial_bootloader_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    usbl_in_if.sink     i_rx,
    usbl_out_if.source  o_tx,
    usbl_cfg_if.sink    i_cfg
);

    usbl_pkg::t_result core_result;
    usbl_pkg::t_result out_result;
    logic              out_free;
    logic              out_valid;
    logic              step;

    assign i_rx.ready  = out_free;
    assign i_cfg.ready = 1'b1;
    assign step        = i_rx.valid && out_free;

    usbl_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_rx_line    (i_rx.rx_line),
        .i_cfg_wr     (i_cfg.valid),
        .i_cfg_period (i_cfg.bit_period),
        .o_result     (core_result)
    );

    usbl_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .i_take   (o_tx.ready),
        .o_valid  (out_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_tx.valid         = out_valid;
    assign o_tx.tx_line       = out_result.tx_line;
    assign o_tx.mem_write     = out_result.mem_write;
    assign o_tx.mem_address   = out_result.mem_address;
    assign o_tx.mem_data      = out_result.mem_data;
    assign o_tx.start_program = out_result.start_program;

endmodule

`default_nettype wire

[rtl/usbl_core.sv]
// Bootloader sequencer: bit timing, UART transmit/receive and payload counting.
// Advances one tick per accepted word. Depends on usbl_pkg.
`default_nettype none

module usbl_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_step,
    input  wire                     i_rx_line,
    input  wire                     i_cfg_wr,
    input  wire [31:0]              i_cfg_period,
    output usbl_pkg::t_result       o_result
);

    usbl_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_period;
    logic [31:0] r_tick, n_tick;
    logic [3:0]  r_bit_idx, n_bit_idx;
    logic [9:0]  r_tx_shift, n_tx_shift;
    logic [7:0]  r_rx_shift, n_rx_shift;
    logic [31:0] r_length, n_length;
    logic [31:0] r_index, n_index;

    logic [31:0] tick_inc;
    logic [3:0]  bit_inc;
    logic        tx_bit, tx_adv, tx_done;
    logic        rx_half, rx_full, rx_deliver;
    logic        is_digit;
    logic [31:0] digit_val;
    logic [31:0] index_inc;
    logic        cr_begin;
    logic        cr_adv;

    // shared tick arithmetic
    always_comb begin
        tick_inc   = r_tick + 32'd1;
        bit_inc    = r_bit_idx + 4'd1;
        tx_bit     = (r_bit_idx < usbl_pkg::FRAME_BITS) ? r_tx_shift[r_bit_idx] : 1'b1;
        tx_adv     = (tick_inc >= r_period);
        tx_done    = tx_adv && (bit_inc >= usbl_pkg::FRAME_BITS);
        rx_half    = (r_bit_idx == usbl_pkg::RX_HALF) && (tick_inc >= (r_period >> 1));
        rx_full    = (tick_inc >= r_period);
        rx_deliver = (r_bit_idx > usbl_pkg::RX_LAST) && rx_full;
        is_digit   = (r_rx_shift >= usbl_pkg::CH_ZERO) && (r_rx_shift <= usbl_pkg::CH_NINE);
        digit_val  = 32'(r_rx_shift - usbl_pkg::CH_ZERO);
        index_inc  = r_index + 32'd1;
        cr_adv     = (32'd1 >= r_period);
        cr_begin   = rx_deliver &&
                     (((r_phase == usbl_pkg::PH_LENGTH) && !is_digit && (r_length == 32'd0)) ||
                      ((r_phase == usbl_pkg::PH_PAYLOAD) && (index_inc >= r_length)));
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit_idx  = r_bit_idx;
        n_tx_shift = r_tx_shift;
        n_rx_shift = r_rx_shift;
        n_length   = r_length;
        n_index    = r_index;

        case (r_phase)
            usbl_pkg::PH_PROMPT, usbl_pkg::PH_CR, usbl_pkg::PH_LF: begin
                n_tick    = tx_adv ? 32'd0 : tick_inc;
                n_bit_idx = tx_adv ? (tx_done ? 4'd0 : bit_inc) : r_bit_idx;
                if (tx_done) begin
                    case (r_phase)
                        usbl_pkg::PH_PROMPT: n_phase = usbl_pkg::PH_LENGTH;
                        usbl_pkg::PH_CR: begin
                            n_phase    = usbl_pkg::PH_LF;
                            n_tx_shift = usbl_pkg::frame_of(usbl_pkg::CH_LF);
                        end
                        default: n_phase = usbl_pkg::PH_START;
                    endcase
                end
            end
            usbl_pkg::PH_LENGTH, usbl_pkg::PH_PAYLOAD: begin
                if (r_bit_idx == usbl_pkg::RX_WAIT) begin
                    if (!i_rx_line) begin
                        n_bit_idx  = usbl_pkg::RX_HALF;
                        n_tick     = 32'd0;
                        n_rx_shift = 8'd0;
                    end
                end else begin
                    n_tick = tick_inc;
                    if (r_bit_idx == usbl_pkg::RX_HALF) begin
                        if (rx_half) begin
                            n_bit_idx = usbl_pkg::RX_FIRST;
                            n_tick    = 32'd0;
                        end
                    end else if (rx_full) begin
                        n_tick = 32'd0;
                        if (r_bit_idx <= usbl_pkg::RX_LAST) begin
                            n_rx_shift = r_rx_shift |
                                (8'(i_rx_line) << 3'(r_bit_idx - usbl_pkg::RX_FIRST));
                            n_bit_idx  = bit_inc;
                        end else begin
                            n_bit_idx = usbl_pkg::RX_WAIT;
                            // same tick looks for the next start bit
                            if (!i_rx_line) begin
                                n_bit_idx  = usbl_pkg::RX_HALF;
                                n_rx_shift = 8'd0;
                            end
                        end
                    end
                end

                if (rx_deliver) begin
                    if (r_phase == usbl_pkg::PH_LENGTH) begin
                        if (is_digit) begin
                            n_length = (r_length << 3) + (r_length << 1) + digit_val;
                        end else begin
                            n_index = 32'd0;
                            n_phase = usbl_pkg::PH_PAYLOAD;
                        end
                    end else begin
                        n_index = index_inc;
                    end
                end

                // CR start bit goes out on the tick the payload ends
                if (cr_begin) begin
                    n_phase    = usbl_pkg::PH_CR;
                    n_tx_shift = usbl_pkg::frame_of(usbl_pkg::CH_CR);
                    n_tick     = cr_adv ? 32'd0 : 32'd1;
                    n_bit_idx  = cr_adv ? 4'd1 : 4'd0;
                    n_rx_shift = r_rx_shift;
                end
            end
            usbl_pkg::PH_START: n_phase = usbl_pkg::PH_HALT;
            default:            n_phase = usbl_pkg::PH_HALT;
        endcase
    end

    // result of this tick
    always_comb begin
        o_result = '0;
        o_result.tx_line = 1'b1;
        case (r_phase)
            usbl_pkg::PH_PROMPT, usbl_pkg::PH_CR, usbl_pkg::PH_LF: begin
                o_result.tx_line = tx_bit;
            end
            usbl_pkg::PH_LENGTH: begin
                o_result.tx_line = !cr_begin;
            end
            usbl_pkg::PH_PAYLOAD: begin
                o_result.tx_line = !cr_begin;
                if (rx_deliver) begin
                    o_result.mem_write   = 1'b1;
                    o_result.mem_address = 16'(r_index & usbl_pkg::ADDR_MASK);
                    o_result.mem_data    = r_rx_shift;
                end
            end
            usbl_pkg::PH_START: o_result.start_program = 1'b1;
            default:            o_result.tx_line = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= usbl_pkg::PH_PROMPT;
            r_period   <= usbl_pkg::RESET_PERIOD;
            r_tick     <= 32'd0;
            r_bit_idx  <= 4'd0;
            r_tx_shift <= usbl_pkg::frame_of(usbl_pkg::CH_PROMPT);
            r_rx_shift <= 8'd0;
            r_length   <= 32'd0;
            r_index    <= 32'd0;
        end else begin
            if (i_cfg_wr) begin
                r_period <= i_cfg_period;
            end
            if (i_step) begin
                r_phase    <= n_phase;
                r_tick     <= n_tick;
                r_bit_idx  <= n_bit_idx;
                r_tx_shift <= n_tx_shift;
                r_rx_shift <= n_rx_shift;
                r_length   <= n_length;
                r_index    <= n_index;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/usbl_out_reg.sv]
// Result register between the sequencer and the output channel.
// Depends on usbl_pkg for the result word type.
`default_nettype none

module usbl_out_reg (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire usbl_pkg::t_result  i_result,
    input  wire                     i_take,
    output logic                    o_valid,
    output logic                    o_free,
    output usbl_pkg::t_result       o_result
);

    logic              r_valid;
    usbl_pkg::t_result r_result;

    // a waiting word may be replaced in the cycle it is taken
    assign o_free   = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire
